[design/polynomial_power_sum_evaluator_top_macros.svh]
// assertion macros used by the term stage
`ifndef POLYNOMIAL_POWER_SUM_EVALUATOR_TOP_MACROS_SVH
`define POLYNOMIAL_POWER_SUM_EVALUATOR_TOP_MACROS_SVH

// condition holds in the same cycle
`define PPSE_ASSERT_NOW(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("ppse assertion failed");

// condition holds in the next cycle
`define PPSE_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("ppse assertion failed");

`endif

[design/ppse_pkg.sv]
package ppse_pkg;

  localparam int MAX_DEGREE = 6;
  localparam int FRAC_BITS  = 16;
  localparam int NUM_COEFS  = MAX_DEGREE + 1;
  localparam int DATA_W     = 32;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int ACC_W      = DATA_W + $clog2(NUM_COEFS + 1);
  localparam int DEG_W      = 3;
  localparam int TERM_W     = $clog2(NUM_COEFS);
  localparam int CFG_IDX_W  = $clog2(NUM_COEFS + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEGREE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COEF_BASE = CFG_IDX_W'(1);

  localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] FX_ONE = DATA_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic [DEG_W-1:0]                  degree_lim;
    logic [NUM_COEFS-1:0][DATA_W-1:0]  coef;
  } ppse_cfg_t;

  // running state handed from one term stage to the next
  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] power;
    logic signed [ACC_W-1:0]  acc;
    logic                     ovf;
  } ppse_carry_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] v;
    logic                     sat;
  } ppse_fx_t;

  // floor shift of a full product back to the fixed-point format, then clamp
  function automatic ppse_fx_t fx_floor_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0]   q;
    logic [PROD_W-DATA_W:0]     upper;
    ppse_fx_t                   r;
    q     = p >>> FRAC_BITS;
    upper = q[PROD_W-1:DATA_W-1];
    r.sat = !((&upper) || !(|upper));
    if (r.sat) begin
      r.v = q[PROD_W-1] ? S_MIN : S_MAX;
    end else begin
      r.v = q[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

[design/ppse_point_if.sv]
interface ppse_point_if import ppse_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] point;

  modport source (output valid, output point, input ready);
  modport sink   (input valid, input point, output ready);
endinterface

[design/ppse_result_if.sv]
interface ppse_result_if import ppse_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic                     overflow;

  modport source (output valid, output value, output overflow, input ready);
  modport sink   (input valid, input value, input overflow, output ready);
endinterface

[design/ppse_cfg_regs.sv]
module ppse_cfg_regs import ppse_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [DATA_W-1:0]    wr_data,
  output ppse_cfg_t            cfg
);

  logic [DEG_W-1:0]                 degree;
  logic [NUM_COEFS-1:0][DATA_W-1:0] coef;
  logic [CFG_IDX_W-1:0]             coef_sel;

  assign coef_sel = wr_index - REG_COEF_BASE;

  always_ff @(posedge clk) begin
    if (rst) begin
      degree <= '0;
      coef   <= '0;
    end else if (wr_en) begin
      if (wr_index == REG_DEGREE) begin
        degree <= wr_data[DEG_W-1:0];
      end else if (coef_sel < CFG_IDX_W'(NUM_COEFS)) begin
        coef[coef_sel[TERM_W-1:0]] <= wr_data;
      end
    end
  end

  // degree beyond the built terms counts as the top degree
  always_comb begin
    cfg.degree_lim = (degree > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : degree;
    cfg.coef       = coef;
  end

endmodule

[design/ppse_term_stage.sv]
`include "polynomial_power_sum_evaluator_top_macros.svh"

module ppse_term_stage import ppse_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [TERM_W-1:0]        term,
  input  logic [DEG_W-1:0]         degree_lim,
  input  logic signed [DATA_W-1:0] coef,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  ppse_carry_t              in_carry,
  output logic                     out_valid,
  input  logic                     out_ready,
  output ppse_carry_t              out_carry
);

  // level a: both products registered
  logic                     a_valid;
  logic signed [DATA_W-1:0] a_x;
  logic signed [ACC_W-1:0]  a_acc;
  logic                     a_ovf;
  logic                     a_use;
  logic                     a_adv;
  logic signed [PROD_W-1:0] a_prod_term;
  logic signed [PROD_W-1:0] a_prod_pow;
  logic                     a_ready;
  logic                     b_ready;

  ppse_fx_t                 term_fx;
  ppse_fx_t                 pow_fx;
  ppse_carry_t              carry_next;

  assign b_ready  = !out_valid || out_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_x         <= in_carry.x;
      a_acc       <= in_carry.acc;
      a_ovf       <= in_carry.ovf;
      a_use       <= (term <= degree_lim);
      a_adv       <= (term < degree_lim);
      a_prod_term <= PROD_W'(in_carry.power) * PROD_W'(coef);
      a_prod_pow  <= PROD_W'(in_carry.power) * PROD_W'(in_carry.x);
    end
  end

  // level b: clamp, add the term, advance the power
  always_comb begin
    term_fx          = fx_floor_sat(a_prod_term);
    pow_fx           = fx_floor_sat(a_prod_pow);
    carry_next.x     = a_x;
    carry_next.power = pow_fx.v;
    carry_next.acc   = a_use ? (a_acc + ACC_W'(term_fx.v)) : a_acc;
    carry_next.ovf   = a_ovf | (a_use & term_fx.sat) | (a_adv & pow_fx.sat);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_ready) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      out_carry <= carry_next;
    end
  end

  `PPSE_ASSERT_NEXT(a_stall_holds, clk, rst, a_valid && !b_ready, a_valid)
  `PPSE_ASSERT_NEXT(b_stall_holds, clk, rst, out_valid && !out_ready,
                    out_valid && $stable(out_carry))
  `PPSE_ASSERT_NEXT(ovf_sticky, clk, rst, in_valid && in_ready && in_carry.ovf,
                    a_valid && a_ovf)
  `PPSE_ASSERT_NEXT(unused_term_keeps_acc, clk, rst, a_valid && b_ready && !a_use,
                    out_valid && out_carry.acc == $past(a_acc))

endmodule

[design/ppse_out_sat.sv]
module ppse_out_sat import ppse_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ppse_carry_t   in_carry,
  ppse_result_if.source results
);

  logic [ACC_W-DATA_W:0]    upper;
  logic                     sum_sat;
  logic signed [DATA_W-1:0] sum_val;

  // final sum clamp to the fixed-point range
  always_comb begin
    upper   = in_carry.acc[ACC_W-1:DATA_W-1];
    sum_sat = !((&upper) || !(|upper));
    if (sum_sat) begin
      sum_val = in_carry.acc[ACC_W-1] ? S_MIN : S_MAX;
    end else begin
      sum_val = in_carry.acc[DATA_W-1:0];
    end
  end

  assign in_ready = !results.valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (in_ready) begin
      results.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      results.value    <= sum_val;
      results.overflow <= in_carry.ovf | sum_sat;
    end
  end

endmodule

[design/polynomial_power_sum_evaluator_top.sv]
// channel    dir   transaction payload
// points     in    point (signed Q16.16)
// results    out   value (signed Q16.16, clamped), overflow
// wr_*       in    register write: index 0 degree, 1..7 coefficient_0..6
//
// one point accepted per cycle unless the result side stalls; a result passes
// two register levels per term for seven terms, plus the output register
// reset clears the valid bits of every stage and the configuration registers to zero
// a stall at the result side holds each full stage; empty stages still fill
module polynomial_power_sum_evaluator_top import ppse_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [DATA_W-1:0]    wr_data,
  ppse_point_if.sink           points,
  ppse_result_if.source        results
);

  ppse_cfg_t   cfg;
  ppse_carry_t carry [NUM_COEFS+1];
  logic [NUM_COEFS:0] cv;
  logic [NUM_COEFS:0] cr;

  ppse_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  // power starts at one, sum at zero
  always_comb begin
    carry[0].x     = points.point;
    carry[0].power = FX_ONE;
    carry[0].acc   = '0;
    carry[0].ovf   = 1'b0;
  end

  assign cv[0]        = points.valid;
  assign points.ready = cr[0];

  for (genvar k = 0; k < NUM_COEFS; k++) begin : g_term
    ppse_term_stage u_term (
      .clk        (clk),
      .rst        (rst),
      .term       (TERM_W'(k)),
      .degree_lim (cfg.degree_lim),
      .coef       ($signed(cfg.coef[k])),
      .in_valid   (cv[k]),
      .in_ready   (cr[k]),
      .in_carry   (carry[k]),
      .out_valid  (cv[k+1]),
      .out_ready  (cr[k+1]),
      .out_carry  (carry[k+1])
    );
  end

  ppse_out_sat u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cv[NUM_COEFS]),
    .in_ready (cr[NUM_COEFS]),
    .in_carry (carry[NUM_COEFS]),
    .results  (results)
  );

endmodule
